### hw/rtl/i2cms_pkg.sv
// Package with the transfer payload types and command codes of the I2C master bit sequencer.
`timescale 1ns / 1ps

package i2cms_pkg;

  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_START   = 3'd1;
  localparam logic [2:0] MODE_STOP    = 3'd2;
  localparam logic [2:0] MODE_WRITE   = 3'd3;
  localparam logic [2:0] MODE_READ    = 3'd4;
  localparam logic [2:0] MODE_RECOVER = 3'd5;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_line;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       slave_ack;
    logic       bus_free;
    logic       rejected;
  } res_t;

endpackage

### hw/rtl/i2cms_stream_if.sv
// Valid/ready stream interface that carries one payload per transfer.
`timescale 1ns / 1ps

interface i2cms_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/i2c_master_bit_sequencer.sv
// Open-drain I2C master that steps START, STOP, byte and recovery sequences one phase per tick.
//
//  Channel  Direction  Payload  Transfer
//  in_i     sink       cmd_t    valid && ready
//  out_o    source     res_t    valid && ready
//
// Every accepted item yields exactly one result, which appears on the output in the cycle after it is taken.
// One item can be accepted in every cycle while the output takes its results; the state update and the result
// are computed combinationally between the sequencer registers and the result register.
// A result waiting in the result register holds the input back; a new item is taken
// while that register is empty or its result leaves in the same cycle.
// Reset leaves the sequencer idle with both pins released and no result pending.
`timescale 1ns / 1ps

module i2c_master_bit_sequencer #(
  parameter int unsigned RECOVER_PULSES = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  i2cms_stream_if.sink   in_i,
  i2cms_stream_if.source out_o
);

  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_ST_SDA1  = 5'd1;
  localparam logic [4:0] PH_ST_SCL1  = 5'd2;
  localparam logic [4:0] PH_ST_SDA0  = 5'd3;
  localparam logic [4:0] PH_ST_SCL0  = 5'd4;
  localparam logic [4:0] PH_SP_SDA0  = 5'd5;
  localparam logic [4:0] PH_SP_SCL1  = 5'd6;
  localparam logic [4:0] PH_SP_SDA1  = 5'd7;
  localparam logic [4:0] PH_WR_DATA  = 5'd8;
  localparam logic [4:0] PH_WR_HI    = 5'd9;
  localparam logic [4:0] PH_WR_LO    = 5'd10;
  localparam logic [4:0] PH_WR_REL   = 5'd11;
  localparam logic [4:0] PH_WR_AHI   = 5'd12;
  localparam logic [4:0] PH_WR_ASMP  = 5'd13;
  localparam logic [4:0] PH_RD_REL   = 5'd14;
  localparam logic [4:0] PH_RD_HI    = 5'd15;
  localparam logic [4:0] PH_RD_SMP   = 5'd16;
  localparam logic [4:0] PH_RD_ACK   = 5'd17;
  localparam logic [4:0] PH_RD_AHI   = 5'd18;
  localparam logic [4:0] PH_RD_ALO   = 5'd19;
  localparam logic [4:0] PH_RD_END   = 5'd20;
  localparam logic [4:0] PH_RC_REL   = 5'd21;
  localparam logic [4:0] PH_RC_CHK   = 5'd22;
  localparam logic [4:0] PH_RC_HI    = 5'd23;
  localparam logic [4:0] PH_RC_SPHI  = 5'd24;
  localparam logic [4:0] PH_RC_SPREL = 5'd25;
  localparam logic [4:0] PH_RC_SMP   = 5'd26;

  localparam logic [3:0] PULSE_LIMIT = 4'(RECOVER_PULSES);
  localparam logic [3:0] BYTE_BITS   = 4'd8;

  logic [4:0] phase_q, phase_d;
  logic [3:0] bit_cnt_q, bit_cnt_d;
  logic [7:0] shift_q, shift_d;
  logic       ack_send_q, ack_send_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       slave_ack_q, slave_ack_d;
  logic       bus_free_q, bus_free_d;
  logic [7:0] read_hold_q, read_hold_d;

  logic                out_valid_q;
  i2cms_pkg::res_t     out_data_q;
  i2cms_pkg::res_t     res;
  i2cms_pkg::cmd_t     cmd;
  logic                accept;
  logic                done;
  logic                rej;

  assign cmd       = in_i.data;
  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign accept    = in_i.valid & in_i.ready;

  always_comb begin
    phase_d     = phase_q;
    bit_cnt_d   = bit_cnt_q;
    shift_d     = shift_q;
    ack_send_d  = ack_send_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    slave_ack_d = slave_ack_q;
    bus_free_d  = bus_free_q;
    read_hold_d = read_hold_q;
    done        = 1'b0;
    rej         = 1'b0;

    if (cmd.mode == i2cms_pkg::MODE_TICK) begin
      case (phase_q)
        PH_ST_SDA1: begin sda_d = 1'b1; phase_d = PH_ST_SCL1; end
        PH_ST_SCL1: begin scl_d = 1'b1; phase_d = PH_ST_SDA0; end
        PH_ST_SDA0: begin sda_d = 1'b0; phase_d = PH_ST_SCL0; end
        PH_ST_SCL0: begin scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1; end
        PH_SP_SDA0: begin sda_d = 1'b0; phase_d = PH_SP_SCL1; end
        PH_SP_SCL1: begin scl_d = 1'b1; phase_d = PH_SP_SDA1; end
        PH_SP_SDA1: begin sda_d = 1'b1; phase_d = PH_IDLE; done = 1'b1; end
        PH_WR_DATA: begin sda_d = shift_q[7]; phase_d = PH_WR_HI; end
        PH_WR_HI:   begin scl_d = 1'b1; phase_d = PH_WR_LO; end
        PH_WR_LO: begin
          scl_d     = 1'b0;
          shift_d   = {shift_q[6:0], 1'b0};
          bit_cnt_d = bit_cnt_q + 4'd1;
          phase_d   = (bit_cnt_d >= BYTE_BITS) ? PH_WR_REL : PH_WR_DATA;
        end
        PH_WR_REL:  begin sda_d = 1'b1; phase_d = PH_WR_AHI; end
        PH_WR_AHI:  begin scl_d = 1'b1; phase_d = PH_WR_ASMP; end
        PH_WR_ASMP: begin
          slave_ack_d = ~cmd.sda_line;
          scl_d       = 1'b0;
          phase_d     = PH_IDLE;
          done        = 1'b1;
        end
        PH_RD_REL:  begin sda_d = 1'b1; phase_d = PH_RD_HI; end
        PH_RD_HI:   begin scl_d = 1'b1; phase_d = PH_RD_SMP; end
        PH_RD_SMP: begin
          shift_d   = {shift_q[6:0], cmd.sda_line};
          scl_d     = 1'b0;
          bit_cnt_d = bit_cnt_q + 4'd1;
          phase_d   = (bit_cnt_d >= BYTE_BITS) ? PH_RD_ACK : PH_RD_HI;
        end
        PH_RD_ACK:  begin sda_d = ~ack_send_q; phase_d = PH_RD_AHI; end
        PH_RD_AHI:  begin scl_d = 1'b1; phase_d = PH_RD_ALO; end
        PH_RD_ALO:  begin scl_d = 1'b0; phase_d = PH_RD_END; end
        PH_RD_END: begin
          sda_d       = 1'b1;
          read_hold_d = shift_q;
          phase_d     = PH_IDLE;
          done        = 1'b1;
        end
        PH_RC_REL:  begin sda_d = 1'b1; phase_d = PH_RC_CHK; end
        PH_RC_CHK: begin
          if ((bit_cnt_q < PULSE_LIMIT) && !cmd.sda_line) begin
            scl_d   = 1'b0;
            phase_d = PH_RC_HI;
          end else begin
            sda_d   = 1'b0;
            phase_d = PH_RC_SPHI;
          end
        end
        PH_RC_HI: begin
          scl_d     = 1'b1;
          bit_cnt_d = bit_cnt_q + 4'd1;
          phase_d   = PH_RC_CHK;
        end
        PH_RC_SPHI:  begin scl_d = 1'b1; phase_d = PH_RC_SPREL; end
        PH_RC_SPREL: begin sda_d = 1'b1; phase_d = PH_RC_SMP; end
        PH_RC_SMP: begin
          bus_free_d = cmd.sda_line;
          phase_d    = PH_IDLE;
          done       = 1'b1;
        end
        default: phase_d = PH_IDLE;
      endcase
    end else if (cmd.mode inside {[i2cms_pkg::MODE_START : i2cms_pkg::MODE_RECOVER]}) begin
      if (phase_q != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        bit_cnt_d = 4'd0;
        case (cmd.mode)
          i2cms_pkg::MODE_START: phase_d = PH_ST_SDA1;
          i2cms_pkg::MODE_STOP:  phase_d = PH_SP_SDA0;
          i2cms_pkg::MODE_WRITE: begin
            shift_d = cmd.write_data;
            phase_d = PH_WR_DATA;
          end
          i2cms_pkg::MODE_READ: begin
            shift_d    = 8'd0;
            ack_send_d = cmd.send_ack;
            phase_d    = PH_RD_REL;
          end
          default: phase_d = PH_RC_REL;
        endcase
      end
    end

    res.scl_level   = scl_d;
    res.sda_release = sda_d;
    res.busy_res    = (phase_d != PH_IDLE);
    res.done_res    = done;
    res.read_data   = read_hold_d;
    res.slave_ack   = slave_ack_d;
    res.bus_free    = bus_free_d;
    res.rejected    = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_cnt_q   <= 4'd0;
      shift_q     <= 8'd0;
      ack_send_q  <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      slave_ack_q <= 1'b0;
      bus_free_q  <= 1'b0;
      read_hold_q <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q     <= phase_d;
        bit_cnt_q   <= bit_cnt_d;
        shift_q     <= shift_d;
        ack_send_q  <= ack_send_d;
        scl_q       <= scl_d;
        sda_q       <= sda_d;
        slave_ack_q <= slave_ack_d;
        bus_free_q  <= bus_free_d;
        read_hold_q <= read_hold_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule
